// ===== hdl/pfc_pkg.sv =====
// ---------------------------------------------------------------------------
// pfc_pkg
// Shared types, codes and helpers for the Playfair digraph cipher.
// ---------------------------------------------------------------------------
package pfc_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELL_COUNT  = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LETTERS     = 26;
    localparam int LETTER_W    = 5;
    localparam int COORD_W     = $clog2(SQUARE_SIDE + 1);
    localparam int CELL_W      = $clog2(CELL_COUNT);

    localparam logic [LETTER_W-1:0] LETTER_A = 5'd0;
    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

    localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(SQUARE_SIDE - 1);
    localparam logic [COORD_W-1:0] FULL_ROW   = COORD_W'(SQUARE_SIDE);

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_KEY     = 3'd1,
        OP_FINISH  = 3'd2,
        OP_ENCRYPT = 3'd3,
        OP_DECRYPT = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_SKIPPED = 2'd2
    } t_status;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FILL  = 9'b000000010,
        S_LOOKA = 9'b000000100,
        S_LOOKB = 9'b000001000,
        S_MAP   = 9'b000010000,
        S_READA = 9'b000100000,
        S_READB = 9'b001000000,
        S_CAPB  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    function automatic logic [COORD_W-1:0] shift_coord(input logic [COORD_W-1:0] v,
                                                       input logic dec);
        logic [COORD_W-1:0] r;
        if (!dec) begin
            r = (v == LAST_COORD) ? '0 : v + 1'b1;
        end else begin
            r = (v == '0) ? LAST_COORD : v - 1'b1;
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                    input logic [COORD_W-1:0] col);
        return CELL_W'(CELL_W'(row) * CELL_W'(SQUARE_SIDE) + CELL_W'(col));
    endfunction

endpackage

// ===== hdl/playfair_digraph_cipher.sv =====
// ---------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair key square builder and letter pair encrypt/decrypt engine.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation word:
//   clear key, key letter, finish key, encrypt pair or decrypt pair.
//   Output channel (o_out_valid / i_out_stall) returns one result word per
//   input word: two letters and a status.
//   Clear, key letter, repeated finish, error and unused operations go
//   straight to the result; finish first makes a 26-step walk over the
//   alphabet, one letter per cycle; a pair first makes two letter-to-cell
//   lookups and two cell reads, one per cycle on the single read port of
//   each table.
//   One word is in work at a time; o_in_stall is high from acceptance until
//   the result moves to the output register, which may still hold an older
//   word waiting to be taken.
//   While i_out_stall holds a result, the output word stays stable and the
//   block holds the next result until the register frees up.
//   Reset empties the key: no cells filled, only j marked used, key
//   unfinished, output empty.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_operation,
    input  logic [pfc_pkg::LETTER_W-1:0]  i_first_letter,
    input  logic [pfc_pkg::LETTER_W-1:0]  i_second_letter,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pfc_pkg::LETTER_W-1:0]  o_out_first,
    output logic [pfc_pkg::LETTER_W-1:0]  o_out_second,
    output logic [1:0]                    o_status
);
    import pfc_pkg::*;

    t_state               r_state, n_state;
    logic [LETTERS-1:0]   r_used, n_used;
    logic [COORD_W-1:0]   r_fill_row, n_fill_row;
    logic [COORD_W-1:0]   r_fill_col, n_fill_col;
    logic                 r_finished, n_finished;
    logic [LETTER_W-1:0]  r_let, n_let;
    logic [LETTER_W-1:0]  r_a, n_a;
    logic [LETTER_W-1:0]  r_b, n_b;
    logic                 r_dec, n_dec;
    logic [COORD_W-1:0]   r_r1, n_r1, r_c1, n_c1, r_r2, n_r2, r_c2, n_c2;
    logic [LETTER_W-1:0]  r_res_first, n_res_first;
    logic [LETTER_W-1:0]  r_res_second, n_res_second;
    logic [1:0]           r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic [LETTER_W-1:0]  r_out_first, n_out_first;
    logic [LETTER_W-1:0]  r_out_second, n_out_second;
    logic [1:0]           r_out_status, n_out_status;

    logic [LETTER_W-1:0]  r_sq [CELL_COUNT];
    logic [2*COORD_W-1:0] r_pos [LETTERS];
    logic [LETTER_W-1:0]  r_sq_rd;
    logic [2*COORD_W-1:0] r_pos_rd;

    logic                 wr_en;
    logic [LETTER_W-1:0]  wr_letter;
    logic [CELL_W-1:0]    sq_rd_addr;
    logic [LETTER_W-1:0]  pos_rd_addr;
    logic                 accept;
    logic                 full;
    logic [LETTER_W-1:0]  ma, mb;
    logic [COORD_W-1:0]   rb, cb;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign full        = (r_fill_row == FULL_ROW);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_first = r_out_first;
    assign o_out_second = r_out_second;
    assign o_status    = r_out_status;

    assign ma = (i_operation == OP_ENCRYPT && i_first_letter == LETTER_J) ?
                LETTER_I : i_first_letter;
    assign mb = (i_operation == OP_ENCRYPT && i_second_letter == LETTER_J) ?
                LETTER_I : i_second_letter;
    assign rb = r_pos_rd[2*COORD_W-1:COORD_W];
    assign cb = r_pos_rd[COORD_W-1:0];

    assign sq_rd_addr  = (r_state == S_READA) ? cell_addr(r_r1, r_c1) : cell_addr(r_r2, r_c2);
    assign pos_rd_addr = (r_state == S_LOOKA) ? r_a : r_b;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_sq[cell_addr(r_fill_row, r_fill_col)] <= wr_letter;
            r_pos[wr_letter]                        <= {r_fill_row, r_fill_col};
        end
        r_sq_rd  <= r_sq[sq_rd_addr];
        r_pos_rd <= r_pos[pos_rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_fill_row   = r_fill_row;
        n_fill_col   = r_fill_col;
        n_finished   = r_finished;
        n_let        = r_let;
        n_a          = r_a;
        n_b          = r_b;
        n_dec        = r_dec;
        n_r1         = r_r1;
        n_c1         = r_c1;
        n_r2         = r_r2;
        n_c2         = r_c2;
        n_res_first  = r_res_first;
        n_res_second = r_res_second;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_status = r_out_status;
        wr_en        = 1'b0;
        wr_letter    = i_first_letter;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_first  = '0;
                    n_res_second = '0;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                    case (i_operation)
                        OP_CLEAR: begin
                            n_used       = '0;
                            n_used[LETTER_J] = 1'b1;
                            n_fill_row   = '0;
                            n_fill_col   = '0;
                            n_finished   = 1'b0;
                        end
                        OP_KEY: begin
                            if (i_first_letter > LETTER_Z || r_finished || full ||
                                r_used[i_first_letter]) begin
                                n_res_status = ST_SKIPPED;
                            end else begin
                                wr_en = 1'b1;
                                n_used[i_first_letter] = 1'b1;
                                if (r_fill_col == LAST_COORD) begin
                                    n_fill_col = '0;
                                    n_fill_row = r_fill_row + 1'b1;
                                end else begin
                                    n_fill_col = r_fill_col + 1'b1;
                                end
                            end
                        end
                        OP_FINISH: begin
                            if (!r_finished) begin
                                n_let   = LETTER_A;
                                n_state = S_FILL;
                            end
                        end
                        OP_ENCRYPT, OP_DECRYPT: begin
                            if (!r_finished || ma > LETTER_Z || mb > LETTER_Z ||
                                ma == LETTER_J || mb == LETTER_J) begin
                                n_res_status = ST_ABSENT;
                            end else begin
                                n_a     = ma;
                                n_b     = mb;
                                n_dec   = (i_operation == OP_DECRYPT);
                                n_state = S_LOOKA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                wr_letter = r_let;
                if (!r_used[r_let[LETTER_W-1:0]] && !full) begin
                    wr_en = 1'b1;
                    n_used[r_let] = 1'b1;
                    if (r_fill_col == LAST_COORD) begin
                        n_fill_col = '0;
                        n_fill_row = r_fill_row + 1'b1;
                    end else begin
                        n_fill_col = r_fill_col + 1'b1;
                    end
                end
                if (r_let == LETTER_Z) begin
                    n_finished = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    n_let = r_let + 1'b1;
                end
            end
            S_LOOKA: begin
                n_state = S_LOOKB;
            end
            S_LOOKB: begin
                n_r1    = r_pos_rd[2*COORD_W-1:COORD_W];
                n_c1    = r_pos_rd[COORD_W-1:0];
                n_state = S_MAP;
            end
            S_MAP: begin
                if (r_r1 == rb) begin
                    n_c1 = shift_coord(r_c1, r_dec);
                    n_c2 = shift_coord(cb, r_dec);
                    n_r2 = rb;
                end else if (r_c1 == cb) begin
                    n_r1 = shift_coord(r_r1, r_dec);
                    n_r2 = shift_coord(rb, r_dec);
                    n_c2 = cb;
                end else begin
                    n_c1 = cb;
                    n_c2 = r_c1;
                    n_r2 = rb;
                end
                n_state = S_READA;
            end
            S_READA: begin
                n_state = S_READB;
            end
            S_READB: begin
                n_res_first = r_sq_rd;
                n_state     = S_CAPB;
            end
            S_CAPB: begin
                n_res_second = r_sq_rd;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_first  = r_res_first;
                    n_out_second = r_res_second;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_used           <= LETTERS'(1) << LETTER_J;
            r_fill_row       <= '0;
            r_fill_col       <= '0;
            r_finished       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_fill_row  <= n_fill_row;
            r_fill_col  <= n_fill_col;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_let        <= n_let;
        r_a          <= n_a;
        r_b          <= n_b;
        r_dec        <= n_dec;
        r_r1         <= n_r1;
        r_c1         <= n_c1;
        r_r2         <= n_r2;
        r_c2         <= n_c2;
        r_res_first  <= n_res_first;
        r_res_second <= n_res_second;
        r_res_status <= n_res_status;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_status <= n_out_status;
    end

endmodule

// ===== tb/playfair_digraph_cipher_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// playfair_digraph_cipher_chk
// Watches both channels of the Playfair cipher, keeps its own key square and
// the predicted result words in order, and counts every mismatch.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher_chk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [2:0]                   i_operation,
    input  logic [pfc_pkg::LETTER_W-1:0] i_first_letter,
    input  logic [pfc_pkg::LETTER_W-1:0] i_second_letter,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [pfc_pkg::LETTER_W-1:0] i_out_first,
    input  logic [pfc_pkg::LETTER_W-1:0] i_out_second,
    input  logic [1:0]                   i_status,
    output int                           o_fail_count,
    output int                           o_pending
);
    import pfc_pkg::*;

    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic [1:0]          status;
    } t_cipher_word;

    logic [LETTER_W-1:0] square [CELL_COUNT];
    logic [LETTERS-1:0]  used_letters;
    int                  cells_filled;
    logic                key_done;
    t_cipher_word        cipher_words[$];
    int                  mismatch_total = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_total < 100) begin
            $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
        end
        mismatch_total++;
    endtask

    function automatic int find_cell(input logic [LETTER_W-1:0] letter);
        for (int k = 0; k < CELL_COUNT; k++) begin
            if (square[k] === letter) begin
                return k;
            end
        end
        return -1;
    endfunction

    task automatic place_letter(input logic [LETTER_W-1:0] letter);
        square[cells_filled] = letter;
        used_letters[letter] = 1'b1;
        cells_filled++;
    endtask

    task automatic predict_word(input logic [2:0] op, input logic [LETTER_W-1:0] a,
                                input logic [LETTER_W-1:0] b, output t_cipher_word word);
        int   pa, pb, r1, c1, r2, c2, shift;
        logic dec;
        word = '0;
        case (op)
            OP_CLEAR: begin
                used_letters = '0;
                used_letters[LETTER_J] = 1'b1;
                cells_filled = 0;
                key_done = 1'b0;
            end
            OP_KEY: begin
                if (a > LETTER_Z || key_done || cells_filled >= CELL_COUNT || used_letters[a]) begin
                    word.status = ST_SKIPPED;
                end else begin
                    place_letter(a);
                end
            end
            OP_FINISH: begin
                for (int n = 0; n < LETTERS; n++) begin
                    if (cells_filled < CELL_COUNT && !used_letters[n]) begin
                        place_letter(LETTER_W'(n));
                    end
                end
                key_done = 1'b1;
            end
            OP_ENCRYPT, OP_DECRYPT: begin
                dec = (op == OP_DECRYPT);
                if (!dec && a == LETTER_J) a = LETTER_I;
                if (!dec && b == LETTER_J) b = LETTER_I;
                pa = find_cell(a);
                pb = find_cell(b);
                if (!key_done || pa < 0 || pb < 0) begin
                    word.status = ST_ABSENT;
                end else begin
                    shift = dec ? SQUARE_SIDE - 1 : 1;
                    r1 = pa / SQUARE_SIDE;
                    c1 = pa % SQUARE_SIDE;
                    r2 = pb / SQUARE_SIDE;
                    c2 = pb % SQUARE_SIDE;
                    if (r1 == r2) begin
                        c1 = (c1 + shift) % SQUARE_SIDE;
                        c2 = (c2 + shift) % SQUARE_SIDE;
                    end else if (c1 == c2) begin
                        r1 = (r1 + shift) % SQUARE_SIDE;
                        r2 = (r2 + shift) % SQUARE_SIDE;
                    end else begin
                        c1 = pb % SQUARE_SIDE;
                        c2 = pa % SQUARE_SIDE;
                    end
                    word.first  = square[r1 * SQUARE_SIDE + c1];
                    word.second = square[r2 * SQUARE_SIDE + c2];
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_cipher_word got, want;
        if (!i_rst_n) begin
            cipher_words.delete();
            used_letters = '0;
            used_letters[LETTER_J] = 1'b1;
            cells_filled = 0;
            key_done = 1'b0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_out_first, i_out_second, i_status};
                if (cipher_words.size() == 0) begin
                    report_mismatch("word with nothing pending, status", got.status, 0);
                end else begin
                    want = cipher_words.pop_front();
                    if (got.first !== want.first) begin
                        report_mismatch("out_first", got.first, want.first);
                    end
                    if (got.second !== want.second) begin
                        report_mismatch("out_second", got.second, want.second);
                    end
                    if (got.status !== want.status) begin
                        report_mismatch("status", got.status, want.status);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_word(i_operation, i_first_letter, i_second_letter, want);
                cipher_words.insert(cipher_words.size(), want);
            end
        end
        o_pending    <= cipher_words.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// ===== tb/playfair_digraph_cipher_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// playfair_digraph_cipher_tb
// Drives key building and pair encrypt/decrypt words into the Playfair cipher
// with random gaps and output stalls, and gives the verdict from the checker.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher_tb;
    import pfc_pkg::*;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int         WORD_TARGET    = 1750;
    localparam int         HOLD_OFF_LEN   = 300;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [2:0]          i_operation;
    logic [LETTER_W-1:0] i_first_letter;
    logic [LETTER_W-1:0] i_second_letter;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [LETTER_W-1:0] o_out_first;
    logic [LETTER_W-1:0] o_out_second;
    logic [1:0]          o_status;

    int   fail_count;
    int   pending_count;
    int   words_sent;
    bit   burst_mode;
    logic hold_off_armed;

    playfair_digraph_cipher u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_first_letter  (i_first_letter),
        .i_second_letter (i_second_letter),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_first     (o_out_first),
        .o_out_second    (o_out_second),
        .o_status        (o_status)
    );

    playfair_digraph_cipher_chk u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_first_letter  (i_first_letter),
        .i_second_letter (i_second_letter),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_first     (o_out_first),
        .i_out_second    (o_out_second),
        .i_status        (o_status),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int hold_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LETTER_W-1:0] pick_letter(input int spare_pct);
        if ($urandom_range(0, 99) < spare_pct) return LETTER_W'($urandom_range(26, 31));
        return LETTER_W'($urandom_range(0, 25));
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [LETTER_W-1:0] first,
                             input logic [LETTER_W-1:0] second);
        int gap;
        gap = (burst_mode || $urandom_range(0, 1) == 0) ? 0 : hold_length();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_first_letter  <= first;
        i_second_letter <= second;
        do @(posedge i_clk); while (o_in_stall);
        if (op <= OP_DECRYPT) words_sent++;
    endtask

    task automatic await_all_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic random_session();
        int                  n;
        logic [LETTER_W-1:0] a;
        if ($urandom_range(0, 9) != 0) send_word(OP_CLEAR, pick_letter(20), pick_letter(20));
        n = $urandom_range(0, 30);
        repeat (n) send_word(OP_KEY, pick_letter(8), pick_letter(20));
        if ($urandom_range(0, 9) != 0) send_word(OP_FINISH, pick_letter(20), pick_letter(20));
        if ($urandom_range(0, 7) == 0) send_word(OP_FINISH, pick_letter(20), pick_letter(20));
        n = $urandom_range(4, 40);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0) begin
                send_word(3'($urandom_range(0, 7)), pick_letter(20), pick_letter(20));
            end else begin
                a = pick_letter(7);
                send_word($urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT, a,
                          $urandom_range(0, 9) == 0 ? a : pick_letter(7));
            end
        end
        if ($urandom_range(0, 5) == 0) await_all_results();
    endtask

    // output side: random stalls, free stretches, one long hold-off
    initial begin
        bit hold_off_done;
        bit stall_on;
        int len;
        int r;
        hold_off_done = 1'b0;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (hold_off_armed && !hold_off_done) begin
                hold_off_done = 1'b1;
                stall_on = 1'b1;
                len = HOLD_OFF_LEN;
            end else if (r < 60) begin
                stall_on = 1'b0;
                len = $urandom_range(1, 12);
            end else if (r < 65) begin
                stall_on = 1'b0;
                len = $urandom_range(40, 120);
            end else begin
                stall_on = 1'b1;
                len = hold_length();
            end
            i_out_stall <= stall_on;
            repeat (len) @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_operation     = OP_CLEAR;
        i_first_letter  = '0;
        i_second_letter = '0;
        hold_off_armed  = 1'b0;
        burst_mode      = 1'b0;
        words_sent      = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // square after this key: z a b c d / e f g h i / k l m n o / p q r s t / u v w x y
        send_word(OP_ENCRYPT, LETTER_A, LETTER_Z);
        send_word(OP_KEY, LETTER_J, LETTER_A);
        send_word(OP_KEY, LETTER_Z, 5'd31);
        send_word(OP_KEY, LETTER_A, LETTER_A);
        send_word(OP_KEY, LETTER_A, LETTER_A);
        send_word(OP_KEY, 5'd31, LETTER_A);
        send_word(OP_FINISH, LETTER_A, LETTER_A);
        send_word(OP_FINISH, 5'd31, 5'd31);
        send_word(OP_KEY, 5'd1, LETTER_A);
        send_word(OP_ENCRYPT, LETTER_Z, 5'd3);
        send_word(OP_DECRYPT, LETTER_Z, 5'd3);
        send_word(OP_ENCRYPT, LETTER_A, 5'd21);
        send_word(OP_DECRYPT, LETTER_A, 5'd21);
        send_word(OP_ENCRYPT, LETTER_Z, 5'd24);
        send_word(OP_ENCRYPT, LETTER_J, 5'd4);
        send_word(OP_ENCRYPT, 5'd1, 5'd1);
        send_word(OP_DECRYPT, LETTER_J, LETTER_A);
        send_word(OP_DECRYPT, 5'd31, LETTER_A);
        send_word(OP_ENCRYPT, LETTER_A, 5'd26);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
            send_word(3'(op), 5'd31, 5'd31);
        end
        send_word(OP_CLEAR, 5'd31, 5'd31);
        send_word(OP_ENCRYPT, LETTER_Z, 5'd24);
        await_all_results();

        // fill the block while the output side holds off
        hold_off_armed <= 1'b1;
        burst_mode = 1'b1;
        random_session();
        burst_mode = 1'b0;

        while (words_sent < WORD_TARGET) begin
            burst_mode = ($urandom_range(0, 9) == 0);
            random_session();
        end
        burst_mode = 1'b0;
        await_all_results();
        repeat (40) @(negedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
